[rtl/assert_macros.svh]
// Assertion macros shared by the clip edge intersection RTL.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CEPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define CEPI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[rtl/cepi_pkg.sv]
// Package for the clip edge / plane intersection core.
// Holds plane codes, queue entry type and the plane distance function.
`timescale 1ns / 1ps

package cepi_pkg;

  localparam int CEPI_FRAC_BITS  = 16;
  localparam int CEPI_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PL_LEFT   = 3'd0,
    PL_RIGHT  = 3'd1,
    PL_BOTTOM = 3'd2,
    PL_TOP    = 3'd3,
    PL_NEAR   = 3'd4,
    PL_FAR    = 3'd5
  } cepi_plane_e;

  typedef enum logic [1:0] {
    TK_ZERO = 2'd0,
    TK_ONE  = 2'd1,
    TK_DIV  = 2'd2
  } cepi_tkind_e;

  // One classified edge, ready for the divider and interpolator.
  typedef struct packed {
    logic              a_out;
    logic              b_out;
    logic              swp;
    logic              zdiv;
    cepi_tkind_e       kind;
    logic [34:0]       n;
    logic [34:0]       d;
    logic [3:0][31:0]  org;
    logic [3:0][32:0]  diff;
  } cepi_entry_t;

  // Signed distance of a vertex from the plane; c is the axis coordinate.
  function automatic logic signed [33:0] plane_dist(input logic [2:0] m,
                                                    input logic signed [31:0] c,
                                                    input logic signed [31:0] w);
    logic signed [33:0] ce;
    logic signed [33:0] we;
    ce = 34'(c);
    we = 34'(w);
    case (m)
      PL_LEFT, PL_BOTTOM:       plane_dist = we + ce;
      PL_RIGHT, PL_TOP, PL_FAR: plane_dist = we - ce;
      PL_NEAR:                  plane_dist = ce;
      default:                  plane_dist = '0;
    endcase
  endfunction

endpackage

[rtl/cepi_front.sv]
// Front end: registers an incoming edge and classifies it for the back end.
// Depends on cepi_pkg.
`timescale 1ns / 1ps

module cepi_front import cepi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   mode_i,
  input  logic [255:0] verts_i,
  output logic         push_o,
  input  logic         push_ready_i,
  output cepi_entry_t  entry_o
);

  logic         v_q, v_d;
  logic [2:0]   mode_q;
  logic [255:0] verts_q;

  assign in_ready_o = !v_q || push_ready_i;
  assign push_o     = v_q;
  assign v_d        = in_ready_o ? in_valid_i : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q  <= mode_i;
      verts_q <= verts_i;
    end
  end

  logic signed [31:0] a [4];
  logic signed [31:0] b [4];
  logic signed [31:0] ca, cb;
  logic [32:0]        ma, mb;
  logic signed [33:0] da, db, dorg, doth;
  logic signed [34:0] den, num;
  logic               mode_ok, swp;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = verts_q[32*i +: 32];
      b[i] = verts_q[128 + 32*i +: 32];
    end
    case (mode_q)
      PL_LEFT, PL_RIGHT:  begin ca = a[0]; cb = b[0]; mode_ok = 1'b1; end
      PL_BOTTOM, PL_TOP:  begin ca = a[1]; cb = b[1]; mode_ok = 1'b1; end
      PL_NEAR, PL_FAR:    begin ca = a[2]; cb = b[2]; mode_ok = 1'b1; end
      default:            begin ca = a[0]; cb = b[0]; mode_ok = 1'b0; end
    endcase
    ma   = ca[31] ? 33'(-34'(ca)) : 33'(ca);
    mb   = cb[31] ? 33'(-34'(cb)) : 33'(cb);
    da   = plane_dist(mode_q, ca, a[3]);
    db   = plane_dist(mode_q, cb, b[3]);
    swp  = mode_ok && (ma < mb);
    dorg = swp ? db : da;
    doth = swp ? da : db;
    num  = 35'(dorg);
    den  = 35'(dorg) - 35'(doth);

    entry_o.a_out = mode_ok && da[33];
    entry_o.b_out = mode_ok && db[33];
    entry_o.swp   = swp;
    entry_o.zdiv  = mode_ok && (den == '0);
    entry_o.n     = num[34] ? 35'(-num) : 35'(num);
    entry_o.d     = den[34] ? 35'(-den) : 35'(den);
    for (int i = 0; i < 4; i++) begin
      entry_o.org[i]  = swp ? b[i] : a[i];
      entry_o.diff[i] = mode_ok ? (swp ? 33'(a[i]) - 33'(b[i]) : 33'(b[i]) - 33'(a[i]))
                                : '0;
    end
    // Zero t for a bad plane, zero divisor, zero numerator or opposite signs.
    if (!mode_ok || den == '0 || num == '0 || (num[34] != den[34])) begin
      entry_o.kind = TK_ZERO;
    end else if (entry_o.n >= entry_o.d) begin
      entry_o.kind = TK_ONE;
    end else begin
      entry_o.kind = TK_DIV;
    end
  end

endmodule

[rtl/cepi_queue.sv]
// Short queue between the front and back ends.
// Depends on cepi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cepi_queue import cepi_pkg::*; #(
  parameter int DEPTH = CEPI_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        push_ready_o,
  input  cepi_entry_t entry_i,
  output logic        pop_valid_o,
  input  logic        pop_i,
  output cepi_entry_t entry_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cepi_entry_t   mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign entry_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `CEPI_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count above depth")
  `CEPI_ASSERT_NEXT(a_push_cnt, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

[rtl/cepi_back.sv]
// Back end: pipelined restoring divider for t, then multiply and round.
// Depends on cepi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cepi_back import cepi_pkg::*; #(
  parameter int FRAC_BITS = CEPI_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         ent_valid_i,
  output logic         ent_pop_o,
  input  cepi_entry_t  entry_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [151:0] out_data_o
);

  localparam int FB = FRAC_BITS;
  localparam int PW = FB + 35;

  typedef struct packed {
    cepi_entry_t   e;
    logic [34:0]   r;
    logic [FB-1:0] q;
  } dstage_t;

  typedef struct packed {
    logic                a_out;
    logic                b_out;
    logic                swp;
    logic                zdiv;
    logic [FB:0]         t;
    logic [3:0][31:0]    org;
    logic [3:0][PW-1:0]  prod;
  } mstage_t;

  localparam logic signed [PW-1:0] HALF = PW'(1) << (FB - 1);

  logic          adv;
  dstage_t       dv_q [FB];
  dstage_t       dv_d [FB];
  logic [FB-1:0] dvld_q;
  mstage_t       mul_q, mul_d;
  logic          mvld_q;
  logic [151:0]  out_q, out_d;
  logic          ovld_q;

  // Advance the whole pipe when the output slot is free or drains.
  assign adv       = !ovld_q || out_ready_i;
  assign ent_pop_o = adv && ent_valid_i;

  for (genvar k = 0; k < FB; k++) begin : g_div
    dstage_t     src;
    logic [35:0] rr;
    logic        ge;
    always_comb begin
      if (k == 0) begin
        src.e = entry_i;
        src.r = entry_i.n;
        src.q = '0;
      end else begin
        src = dv_q[(k == 0) ? 0 : k - 1];
      end
      rr       = {src.r, 1'b0};
      ge       = rr >= {1'b0, src.e.d};
      dv_d[k]  = src;
      dv_d[k].r = ge ? 35'(rr - {1'b0, src.e.d}) : rr[34:0];
      dv_d[k].q = {src.q[FB-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  always_comb begin
    dstage_t last;
    last          = dv_q[FB-1];
    mul_d.a_out   = last.e.a_out;
    mul_d.b_out   = last.e.b_out;
    mul_d.swp     = last.e.swp;
    mul_d.zdiv    = last.e.zdiv;
    case (last.e.kind)
      TK_ONE:  mul_d.t = (FB + 1)'(1) << FB;
      TK_DIV:  mul_d.t = {1'b0, last.q};
      default: mul_d.t = '0;
    endcase
    mul_d.org = last.e.org;
    for (int i = 0; i < 4; i++) begin
      mul_d.prod[i] = PW'($signed({1'b0, mul_d.t}) * $signed(last.e.diff[i]));
    end
  end

  always_comb begin
    logic signed [PW-1:0] rnd;
    logic [FB+32:0]       tx;
    tx    = (FB + 33)'(mul_q.t);
    out_d = '0;
    out_d[0]    = mul_q.a_out;
    out_d[1]    = mul_q.b_out;
    out_d[18:2] = tx[16:0];
    for (int i = 0; i < 4; i++) begin
      rnd = ($signed(mul_q.prod[i]) + HALF) >>> FB;
      out_d[19 + 32*i +: 32] = mul_q.org[i] + rnd[31:0];
    end
    out_d[147] = mul_q.swp;
    out_d[148] = mul_q.zdiv;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
      mvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (adv) begin
      dvld_q <= {dvld_q[FB-2:0], ent_valid_i};
      mvld_q <= dvld_q[FB-1];
      ovld_q <= mvld_q;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

  `CEPI_ASSERT_ALWAYS(a_t_range, !mvld_q || mul_q.t <= ((FB + 1)'(1) << FB), "t above one")
  `CEPI_ASSERT_ALWAYS(a_zdiv_t, !mvld_q || !mul_q.zdiv || mul_q.t == '0, "zero divisor, t set")

endmodule

[rtl/clip_edge_plane_intersect_core.sv]
// Top level of the clip edge / plane intersection core.
// Depends on cepi_pkg, cepi_front, cepi_queue and cepi_back.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one word is one edge. tuser[2:0] selects the plane
//   (left, right, bottom, top, near, far); tdata holds vertex A then B,
//   each x,y,z,w in signed Q16.16.
//   Master stream: one word per edge with the outside flags, the clamped
//   crossing parameter t, the hit position and the swapped and zero
//   divisor flags.
//   Throughput is one edge per cycle when nothing stalls. From accept to
//   tvalid an edge passes the front register, where it is classified, a queue slot,
//   FRAC_BITS divider stages (one quotient bit each, the first fed straight
//   from the queue head), a multiply stage and the output register.
//   Reset clears all valid state; no word is held afterwards.
//   When the receiver stalls, the back pipeline holds in place, the queue
//   fills, and only then does s_axis_tready_o drop. The front keeps
//   taking words while results wait.
//   Plane codes six and seven pass vertex A through with t and flags zero.

module clip_edge_plane_intersect_core import cepi_pkg::*; #(
  parameter int FRAC_BITS   = CEPI_FRAC_BITS,
  parameter int QUEUE_DEPTH = CEPI_QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (32 bits each)
  input  logic [255:0] s_axis_tdata_i,
  // mode (3 bits)
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // a_outside, b_outside, cross_t (17), hit_x, hit_y, hit_z, hit_w (32 each),
  // swapped, zero_divisor, three zero bits
  output logic [151:0] m_axis_tdata_o
);

  cepi_entry_t fr_entry, q_entry;
  logic        push, push_ready, q_valid, pop;

  // Register and classify each incoming edge.
  cepi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .mode_i       (s_axis_tuser_i),
    .verts_i      (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (fr_entry)
  );

  // Decouple front from back so each side stalls on its own.
  cepi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .entry_i      (fr_entry),
    .pop_valid_o  (q_valid),
    .pop_i        (pop),
    .entry_o      (q_entry)
  );

  // Divide, multiply, round and hold the result word.
  cepi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (q_valid),
    .ent_pop_o   (pop),
    .entry_i     (q_entry),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
